>>> src/bsrr_pkg.sv
`default_nettype none

package bsrr_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 16;
  localparam int unsigned DATA_WIDTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_REVERSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped_value;
    logic               is_empty;
    logic [4:0]         entry_total;
  } out_rsp_t;

endpackage

`default_nettype wire

>>> src/bsrr_ram.sv
`default_nettype none

module bsrr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/bounded_stack_remove_reverse_top.sv
`default_nettype none

// Bounded LIFO stack of up to DEPTH values with pop, remove-by-value and
// order reversal. The entries live in a ring held in one single-port-write,
// registered-read RAM; a head index and a direction flag say where the top
// is, so reverse is a flag flip and never moves data. Each request gives
// exactly one response with status, popped value, empty flag and count.
// The RAM has a registered read: push and reverse pass from a dispatch
// state straight to the response state, while pop issues its read at
// dispatch and takes the data in a pop-read state. Remove scans from the
// top at one entry per cycle, then closes the gap by copying each deeper
// entry one slot up at one entry per cycle and drops the bottom slot in a
// last step; a remove that finds nothing skips the copy. One request is
// worked at a time; a new request is taken as soon as the previous
// response sits in the output register, even if the consumer has not yet
// taken it. Values are stored and compared on their low DATA_WIDTH bits;
// popped values come back zero-extended. The RAM needs no clearing after
// reset.
module bounded_stack_remove_reverse_top #(
  parameter int unsigned DEPTH      = bsrr_pkg::DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = bsrr_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bsrr_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bsrr_pkg::out_rsp_t     out_rsp_o
);

  import bsrr_pkg::*;

  // ring address and entry count widths
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_POPRD    = 3'd2;
  localparam logic [2:0] S_SEARCH   = 3'd3;
  localparam logic [2:0] S_SHIFT    = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  logic [2:0]            state_q, state_d;
  op_e                   op_q, op_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  flip_q, flip_d;
  logic [CNT_W-1:0]      pos_q, pos_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] popped_q, popped_d;
  logic                  out_valid_q, out_valid_d;
  out_rsp_t              out_q, out_d;

  // ram port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // width adapters between fixed port fields and parameterized storage
  logic [DATA_WIDTH+31:0] in_val_ext;
  logic [DATA_WIDTH+31:0] popped_ext;
  logic [CNT_W+4:0]       count_ext;

  // derived ring positions
  logic [AW-1:0]  head_inc, head_dec;
  logic [CNT_W:0] pos_plus1, pos_plus2;
  logic           pos1_in, pos2_in;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // ring slot of logical position pos (0 is the top), pos below count
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CNT_W-1:0] count,
                                             input logic flip,
                                             input logic [CNT_W-1:0] pos);
    logic [CNT_W-1:0] off;
    off = flip ? (count - CNT_W'(1) - pos) : pos;
    return ring_add(head, off);
  endfunction

  assign in_val_ext = {{DATA_WIDTH{1'b0}}, in_req_i.value};
  assign popped_ext = {32'd0, popped_q};
  assign count_ext  = {5'd0, count_q};

  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  assign pos_plus1 = {1'b0, pos_q} + (CNT_W + 1)'(1);
  assign pos_plus2 = {1'b0, pos_q} + (CNT_W + 1)'(2);
  assign pos1_in   = pos_plus1 < {1'b0, count_q};
  assign pos2_in   = pos_plus2 < {1'b0, count_q};

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    head_d      = head_q;
    count_d     = count_q;
    flip_d      = flip_q;
    pos_d       = pos_q;
    status_d    = status_q;
    popped_d    = popped_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = val_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_req_i.operation;
          val_d    = in_val_ext[DATA_WIDTH-1:0];
          status_d = ST_OK;
          popped_d = '0;
          state_d  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_d = S_RESP;
        case (op_q)
          OP_PUSH: begin
            if (count_q == CNT_W'(DEPTH)) begin
              status_d = ST_FULL;
            end else if (!flip_q) begin
              // top sits at head: grow downward
              mem_we    = 1'b1;
              mem_waddr = head_dec;
              head_d    = head_dec;
              count_d   = count_q + CNT_W'(1);
            end else begin
              // top sits at the far end: grow upward
              mem_we    = 1'b1;
              mem_waddr = ring_add(head_q, count_q);
              count_d   = count_q + CNT_W'(1);
            end
          end
          OP_POP: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot_of(head_q, count_q, flip_q, '0);
              state_d   = S_POPRD;
            end
          end
          OP_REMOVE: begin
            if (count_q == '0) begin
              status_d = ST_NOT_FOUND;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot_of(head_q, count_q, flip_q, '0);
              pos_d     = '0;
              state_d   = S_SEARCH;
            end
          end
          OP_REVERSE: begin
            if (count_q > CNT_W'(1)) begin
              flip_d = !flip_q;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      S_POPRD: begin
        popped_d = mem_rdata;
        if (!flip_q) begin
          head_d = head_inc;
        end
        count_d = count_q - CNT_W'(1);
        state_d = S_RESP;
      end

      S_SEARCH: begin
        // read data holds the entry at pos; prefetch the next one
        if (pos1_in) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_q, count_q, flip_q, pos_plus1[CNT_W-1:0]);
        end
        if (mem_rdata == val_q) begin
          state_d = S_SHIFT;
        end else if (pos1_in) begin
          pos_d = pos_plus1[CNT_W-1:0];
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end
      end

      S_SHIFT: begin
        // read data holds the entry at pos + 1; move it up into pos
        if (pos1_in) begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(head_q, count_q, flip_q, pos_q);
          mem_wdata = mem_rdata;
          if (pos2_in) begin
            mem_re    = 1'b1;
            mem_raddr = slot_of(head_q, count_q, flip_q, pos_plus2[CNT_W-1:0]);
          end
          pos_d = pos_plus1[CNT_W-1:0];
        end else begin
          // drop the bottom entry
          if (flip_q) begin
            head_d = head_inc;
          end
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = status_q;
          out_d.popped_value = signed'(popped_ext[31:0]);
          out_d.is_empty     = (count_q == '0);
          out_d.entry_total  = count_ext[4:0];
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      flip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      flip_q      <= flip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    popped_q <= popped_d;
    out_q    <= out_d;
  end

  bsrr_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

endmodule

`default_nettype wire
